/* hw/rtl/ovn_pkg.sv */
// Shared constants for the octave value noise core.
package ovn_pkg;

   // field and register widths
   localparam int COORD_W    = 16;
   localparam int OCT_W      = 6;
   localparam int PERS_W     = 16;
   localparam int FREQ_W     = 24;
   localparam int BAMP_W     = 16;
   localparam int SUM_W      = 40;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam int WEIGHT_W   = 17;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OCTAVE_COUNT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERSISTENCE    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_FREQUENCY = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_AMPLITUDE = 4'd3;

   // reset values
   localparam logic [OCT_W-1:0]  RST_OCTAVE_COUNT   = 6'd1;
   localparam logic [PERS_W-1:0] RST_PERSISTENCE    = 16'd16384;
   localparam logic [FREQ_W-1:0] RST_BASE_FREQUENCY = 24'd65536;
   localparam logic [BAMP_W-1:0] RST_BASE_AMPLITUDE = 16'd256;

   // parameter defaults
   localparam int DEF_MAX_OCTAVES        = 32;
   localparam int DEF_WEIGHT_TABLE_DEPTH = 1024;

   // arithmetic constants
   localparam logic [63:0] PI_Q30    = 64'd3373259426;
   localparam logic [63:0] ONE_Q30   = 64'd1073741824;
   localparam logic [47:0] AMP_MAX   = 48'h7FFF_FFFF_FFFF;
   localparam logic [31:0] HASH_K1   = 32'd15731;
   localparam logic [31:0] HASH_K2   = 32'd789221;
   localparam logic [31:0] HASH_K3   = 32'd1376312589;
   localparam logic [31:0] LAT_ROW   = 32'd57;

endpackage

/* hw/rtl/octave_value_noise_core.sv */
// Octave value noise core: fractal sum of cosine-blended lattice value noise.
//
// Usage: pulse start with req_mode, req_x_coord and req_y_coord while busy is
// low; the sample is taken on that edge and busy rises. The core then issues
// one octave per cycle into an 11-stage octave pipeline (scale, ROM lookup,
// three hash multiplies, two blend levels, amplitude product) followed by the
// accumulate and saturate register.
// The saturated sum shows on rsp_noise_sum for exactly one cycle with
// rsp_strobe high, and busy drops in that same cycle. The strobe follows
// the prep state, the octave issues and the pipeline. A new start is taken
// in the strobe cycle at the earliest: the octave issue sequencer runs one
// sample at a time and feeds the pipeline one octave each cycle.
// Configuration: csr_write with csr_index and csr_wdata writes one register
// (0 octave_count, 1 persistence, 2 base_frequency, 3 base_amplitude);
// the user must write only while busy is low (not enforced by the block).
// Other indexes are dropped. Synchronous reset returns the registers to
// their defaults and aborts any sample in flight. The receiver has no back
// pressure: each result transfer completes in its strobe cycle.
module octave_value_noise_core #(
   parameter int MAX_OCTAVES        = ovn_pkg::DEF_MAX_OCTAVES,
   parameter int WEIGHT_TABLE_DEPTH = ovn_pkg::DEF_WEIGHT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [ovn_pkg::COORD_W-1:0]       req_x_coord,
   input  logic [ovn_pkg::COORD_W-1:0]       req_y_coord,
   output logic                              rsp_strobe,
   output logic signed [ovn_pkg::SUM_W-1:0]  rsp_noise_sum,
   input  logic                              csr_write,
   input  logic [ovn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ovn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IW   = $clog2(WEIGHT_TABLE_DEPTH);
   localparam int WW   = ovn_pkg::WEIGHT_W;
   localparam int NSTG = 11;

   // angle scale divisor for the ROM fill
   localparam logic [63:0] WTAB_ZDIV = 64'(2 * WEIGHT_TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PREP  = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   typedef logic [WW-1:0] wtab_type [WEIGHT_TABLE_DEPTH];

   // cosine weight ROM contents, (1 - cos(pi*t))/2 in Q16
   function automatic wtab_type build_wtab();
      wtab_type    tab;
      logic [63:0] d, two, a, z, z2, r, s;
      d = 64'(WEIGHT_TABLE_DEPTH);
      for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++) begin
         two = 64'(2 * i);
         a   = (two >= d) ? two - d : d - two;
         z   = (a * ovn_pkg::PI_Q30) / WTAB_ZDIV;
         z2  = (z * z) >> 30;
         r   = ovn_pkg::ONE_Q30 - z2 / 64'd72;
         r   = ovn_pkg::ONE_Q30 - ((z2 * r) >> 30) / 64'd42;
         r   = ovn_pkg::ONE_Q30 - ((z2 * r) >> 30) / 64'd20;
         r   = ovn_pkg::ONE_Q30 - ((z2 * r) >> 30) / 64'd6;
         s   = (z * r) >> 30;
         if (s > ovn_pkg::ONE_Q30) begin
            s = ovn_pkg::ONE_Q30;
         end
         if (two >= d) begin
            tab[i] = WW'((ovn_pkg::ONE_Q30 + s + 64'd16384) >> 15);
         end else begin
            tab[i] = WW'((ovn_pkg::ONE_Q30 - s + 64'd16384) >> 15);
         end
      end
      return tab;
   endfunction

   localparam wtab_type WTAB = build_wtab();

   // lattice hash pre-mix
   function automatic logic [31:0] hmix(input logic [31:0] n);
      return (n << 13) ^ n;
   endfunction

   // ---------------- configuration registers ----------------
   logic [ovn_pkg::OCT_W-1:0]  oct_cnt_ff;
   logic [ovn_pkg::PERS_W-1:0] pers_ff;
   logic [ovn_pkg::FREQ_W-1:0] freq_ff;
   logic [ovn_pkg::BAMP_W-1:0] bamp_ff;
   logic [ovn_pkg::OCT_W-1:0]  oct_wr;

   always_comb begin
      oct_wr = csr_wdata[ovn_pkg::OCT_W-1:0];
      if (oct_wr == '0) begin
         oct_wr = ovn_pkg::OCT_W'(1);
      end else if (oct_wr > ovn_pkg::OCT_W'(MAX_OCTAVES)) begin
         oct_wr = ovn_pkg::OCT_W'(MAX_OCTAVES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cnt_ff <= ovn_pkg::RST_OCTAVE_COUNT;
         pers_ff    <= ovn_pkg::RST_PERSISTENCE;
         freq_ff    <= ovn_pkg::RST_BASE_FREQUENCY;
         bamp_ff    <= ovn_pkg::RST_BASE_AMPLITUDE;
      end else if (csr_write) begin
         case (csr_index)
            ovn_pkg::REG_OCTAVE_COUNT:   oct_cnt_ff <= oct_wr;
            ovn_pkg::REG_PERSISTENCE:    pers_ff    <= csr_wdata[ovn_pkg::PERS_W-1:0];
            ovn_pkg::REG_BASE_FREQUENCY: freq_ff    <= csr_wdata;
            ovn_pkg::REG_BASE_AMPLITUDE: bamp_ff    <= csr_wdata[ovn_pkg::BAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- octave issue sequencer ----------------
   logic [1:0]  state_ff, state_in;
   logic        busy_ff, busy_in;
   logic [ovn_pkg::OCT_W-1:0] oct_ff, oct_in;
   logic        mode_ff;
   logic        amp_neg_ff;
   logic [15:0] xc_ff, yc_ff;
   logic [39:0] px_ff, py_ff;
   logic [47:0] amp_ff, amp_in;
   logic [63:0] amp_prod;
   logic [48:0] amp_sh;
   logic [16:0] bamp_mag;
   logic        accept, issue, issue_last, out_fire;

   assign accept     = start && !busy_ff;
   assign issue      = (state_ff == ST_ISSUE);
   assign issue_last = issue && (oct_ff == oct_cnt_ff - ovn_pkg::OCT_W'(1));
   assign bamp_mag   = bamp_ff[15] ? 17'(-$signed({bamp_ff[15], bamp_ff}))
                                   : {1'b0, bamp_ff};
   assign amp_prod   = 64'(amp_ff) * 64'(pers_ff);
   assign amp_sh     = amp_prod[63:15];

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      oct_in   = oct_ff;
      amp_in   = amp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PREP;
               busy_in  = 1'b1;
            end
         end
         ST_PREP: begin
            state_in = ST_ISSUE;
            oct_in   = '0;
            amp_in   = {15'd0, bamp_mag, 16'd0};
         end
         ST_ISSUE: begin
            oct_in = oct_ff + ovn_pkg::OCT_W'(1);
            amp_in = (amp_sh > 49'(ovn_pkg::AMP_MAX)) ? ovn_pkg::AMP_MAX : amp_sh[47:0];
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_fire) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         oct_ff   <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         oct_ff   <= oct_in;
      end
      amp_ff <= amp_in;
      if (accept) begin
         mode_ff    <= req_mode;
         xc_ff      <= req_x_coord;
         yc_ff      <= req_y_coord;
         amp_neg_ff <= bamp_ff[15];
      end
      // scaled coordinates once per sample
      if (state_ff == ST_PREP) begin
         px_ff <= 40'(xc_ff) * 40'(freq_ff);
         py_ff <= 40'(yc_ff) * 40'(freq_ff);
      end
   end

   assign busy = busy_ff;

   // ---------------- pipeline control ----------------
   logic [NSTG:1] vld_ff, lst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         lst_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-1:1], issue};
         lst_ff <= {lst_ff[NSTG-1:1], issue_last};
      end
   end

   // ---------------- s1: octave scaling ----------------
   logic [47:0] tx, ty;
   logic [31:0] xi1_ff, yi1_ff;
   logic [15:0] xf1_ff, yf1_ff;
   logic [47:0] amp1_ff;

   assign tx = 48'(px_ff) << oct_ff[4:0];
   assign ty = 48'(py_ff) << oct_ff[4:0];

   always_ff @(posedge clock) begin
      xi1_ff  <= tx[47:16];
      xf1_ff  <= tx[15:0];
      yi1_ff  <= ty[47:16];
      yf1_ff  <= ty[15:0];
      amp1_ff <= amp_ff;
   end

   // ---------------- s2: weight ROM and lattice corners ----------------
   logic [32:0] xsel, ysel;
   logic [IW-1:0] xidx, yidx;
   logic [31:0] b0;
   logic [31:0] n2_ff [4];
   logic [WW-1:0] wx2_ff, wy2_ff;
   logic [47:0] amp2_ff;

   assign xsel = 33'(xf1_ff) * 33'(WEIGHT_TABLE_DEPTH);
   assign ysel = 33'(yf1_ff) * 33'(WEIGHT_TABLE_DEPTH);
   assign xidx = xsel[16 +: IW];
   assign yidx = ysel[16 +: IW];
   assign b0   = xi1_ff + (yi1_ff << 5) + (yi1_ff << 4) + (yi1_ff << 3) + yi1_ff;

   always_ff @(posedge clock) begin
      wx2_ff <= WTAB[xidx];
      wy2_ff <= WTAB[yidx];
      if (mode_ff) begin
         n2_ff[0] <= hmix(b0);
         n2_ff[1] <= hmix(b0 + 32'd1);
         n2_ff[2] <= hmix(b0 + ovn_pkg::LAT_ROW);
         n2_ff[3] <= hmix(b0 + ovn_pkg::LAT_ROW + 32'd1);
      end else begin
         n2_ff[0] <= hmix(xi1_ff);
         n2_ff[1] <= hmix(xi1_ff + 32'd1);
         n2_ff[2] <= hmix(xi1_ff);
         n2_ff[3] <= hmix(xi1_ff + 32'd1);
      end
      amp2_ff <= amp1_ff;
   end

   // ---------------- s3..s5: integer hash, four lanes ----------------
   logic [31:0] n3_ff [4], sq3_ff [4];
   logic [31:0] n4_ff [4], m4_ff [4];
   logic [31:0] h5 [4];
   logic signed [31:0] cv5_ff [4];
   logic [WW-1:0] wx3_ff, wy3_ff, wx4_ff, wy4_ff, wx5_ff, wy5_ff;
   logic [47:0] amp3_ff, amp4_ff, amp5_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         h5[k] = n4_ff[k] * m4_ff[k] + ovn_pkg::HASH_K3;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         n3_ff[k]  <= n2_ff[k];
         sq3_ff[k] <= n2_ff[k] * n2_ff[k];
         n4_ff[k]  <= n3_ff[k];
         m4_ff[k]  <= sq3_ff[k] * ovn_pkg::HASH_K1 + ovn_pkg::HASH_K2;
         cv5_ff[k] <= $signed(32'(ovn_pkg::ONE_Q30) - {1'b0, h5[k][30:0]});
      end
      wx3_ff <= wx2_ff;  wy3_ff <= wy2_ff;
      wx4_ff <= wx3_ff;  wy4_ff <= wy3_ff;
      wx5_ff <= wx4_ff;  wy5_ff <= wy4_ff;
      amp3_ff <= amp2_ff;
      amp4_ff <= amp3_ff;
      amp5_ff <= amp4_ff;
   end

   // ---------------- s6..s7: blend along x ----------------
   logic signed [17:0] wxa, wxb;
   logic signed [49:0] pa6_ff [2], pb6_ff [2];
   logic signed [50:0] rs7 [2];
   logic signed [31:0] r7_ff [2];
   logic [WW-1:0] wy6_ff, wy7_ff;
   logic [47:0] amp6_ff, amp7_ff;

   assign wxa = $signed({1'b0, 17'(18'd65536 - 18'(wx5_ff))});
   assign wxb = $signed({1'b0, wx5_ff});

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         rs7[k] = 51'(pa6_ff[k]) + 51'(pb6_ff[k]) + 51'sd32768;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         pa6_ff[k] <= cv5_ff[2*k]   * wxa;
         pb6_ff[k] <= cv5_ff[2*k+1] * wxb;
         r7_ff[k]  <= rs7[k][47:16];
      end
      wy6_ff  <= wy5_ff;
      wy7_ff  <= wy6_ff;
      amp6_ff <= amp5_ff;
      amp7_ff <= amp6_ff;
   end

   // ---------------- s8..s9: blend along y, mode 1 only ----------------
   logic signed [17:0] wya, wyb;
   logic signed [49:0] qa8_ff, qb8_ff;
   logic signed [50:0] qs9;
   logic signed [31:0] r8_ff, v9_ff;
   logic [47:0] amp8_ff, amp9_ff;

   assign wya = $signed({1'b0, 17'(18'd65536 - 18'(wy7_ff))});
   assign wyb = $signed({1'b0, wy7_ff});
   assign qs9 = 51'(qa8_ff) + 51'(qb8_ff) + 51'sd32768;

   always_ff @(posedge clock) begin
      qa8_ff  <= r7_ff[0] * wya;
      qb8_ff  <= r7_ff[1] * wyb;
      r8_ff   <= r7_ff[0];
      v9_ff   <= mode_ff ? qs9[47:16] : r8_ff;
      amp8_ff <= amp7_ff;
      amp9_ff <= amp8_ff;
   end

   // ---------------- s10..s11: amplitude product ----------------
   logic [30:0] vm9;
   logic [54:0] hi10_ff, lo10_ff;
   logic        neg10_ff;
   logic [55:0] tsum11;
   logic signed [41:0] term11_ff;

   assign vm9    = v9_ff[31] ? 31'(-v9_ff) : v9_ff[30:0];
   assign tsum11 = 56'(hi10_ff) + 56'(lo10_ff[54:24]);

   always_ff @(posedge clock) begin
      hi10_ff  <= 55'(vm9) * 55'(amp9_ff[47:24]);
      lo10_ff  <= 55'(vm9) * 55'(amp9_ff[23:0]);
      neg10_ff <= v9_ff[31] ^ amp_neg_ff;
      term11_ff <= neg10_ff ? -$signed({1'b0, tsum11[54:14]})
                            :  $signed({1'b0, tsum11[54:14]});
   end

   // ---------------- accumulate and saturate ----------------
   localparam logic signed [47:0] SUM_MAX = 48'sh00_7F_FFFF_FFFF;
   localparam logic signed [47:0] SUM_MIN = -48'sh00_80_0000_0000;

   logic signed [47:0] acc_ff, acc_in;
   logic               strobe_ff;
   logic signed [ovn_pkg::SUM_W-1:0] sum_ff;

   assign acc_in   = acc_ff + 48'(term11_ff);
   assign out_fire = vld_ff[NSTG] && lst_ff[NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= out_fire;
      end
      if (accept) begin
         acc_ff <= '0;
      end else if (vld_ff[NSTG]) begin
         acc_ff <= acc_in;
      end
      if (acc_in > SUM_MAX) begin
         sum_ff <= SUM_MAX[ovn_pkg::SUM_W-1:0];
      end else if (acc_in < SUM_MIN) begin
         sum_ff <= SUM_MIN[ovn_pkg::SUM_W-1:0];
      end else begin
         sum_ff <= acc_in[ovn_pkg::SUM_W-1:0];
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_noise_sum = sum_ff;

   // ---------------- assertions ----------------
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted sample did not raise busy");

   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      out_fire |-> (state_ff == ST_DRAIN))
      else $error("final octave left the pipe outside drain");

   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (oct_ff < oct_cnt_ff))
      else $error("octave issued past octave count");

   a_pipe_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (vld_ff == '0))
      else $error("pipeline active while idle");

endmodule
